### hdl/rtsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtsm_pkg
// Types and constants shared by the random tile subset mask block.
// ----------------------------------------------------------------------------
package rtsm_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int TILE_W    = 5;
    localparam int PROD_W    = 15;               // 255*107+7 = 27292 < 2**15
    localparam int DIV_STEPS = PROD_W;           // one quotient bit per cycle
    localparam int CNT_W     = 4;                // counts 0 .. DIV_STEPS

    localparam logic [PROD_W-1:0] PICK_MUL   = 15'd107;
    localparam logic [PROD_W-1:0] PICK_ADD   = 15'd7;
    localparam logic [TILE_W-1:0] RESET_FREE = 5'd12;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture sample product, clear remainder
        logic step;     // one restoring-division step
        logic update;   // draw the tile, shift the deck, load the output beat
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_busy; // output register holds a beat that is not taken this cycle
    } t_dp_sts;

endpackage
`default_nettype wire

### hdl/rtsm_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtsm_in_if
// Sample channel: one random byte per beat.
// ----------------------------------------------------------------------------
interface rtsm_in_if;
    logic                           valid;
    logic                           ready;
    logic [rtsm_pkg::SAMPLE_W-1:0]  random_byte;

    modport source (output valid, output random_byte, input ready);
    modport sink   (input valid, input random_byte, output ready);
endinterface
`default_nettype wire

### hdl/rtsm_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtsm_out_if
// Draw channel: tile drawn, running mask and end-of-set flag per beat.
// ----------------------------------------------------------------------------
interface rtsm_out_if #(
    parameter int TILES = 25
);
    logic                         valid;
    logic                         ready;
    logic [rtsm_pkg::TILE_W-1:0]  tile;
    logic [TILES-1:0]             mask;
    logic                         last;

    modport source (output valid, output tile, output mask, output last, input ready);
    modport sink   (input valid, input tile, input mask, input last, output ready);
endinterface
`default_nettype wire

### hdl/rtsm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtsm_ctrl
// Sequencer: accept a sample, run the division steps, issue the update.
// ----------------------------------------------------------------------------
module rtsm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire rtsm_pkg::t_dp_sts i_sts,
    output rtsm_pkg::t_dp_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    localparam logic [rtsm_pkg::CNT_W-1:0] CNT_LAST =
        rtsm_pkg::CNT_W'(rtsm_pkg::DIV_STEPS - 1);

    logic [1:0]                  r_state, n_state;
    logic [rtsm_pkg::CNT_W-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                // hold until the output register can take the beat
                if (!i_sts.out_busy) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

### hdl/rtsm_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtsm_dpath
// Deck, mask, draw counter, serial modulo unit and output register.
// ----------------------------------------------------------------------------
module rtsm_dpath #(
    parameter int TILES = 25,
    parameter int DRAWS = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rtsm_pkg::t_dp_cmd             i_cmd,
    output rtsm_pkg::t_dp_sts                  o_sts,
    input  wire logic                          i_cfg_we,
    input  wire logic [rtsm_pkg::TILE_W-1:0]   i_cfg_data,
    input  wire logic [rtsm_pkg::SAMPLE_W-1:0] i_random_byte,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [rtsm_pkg::TILE_W-1:0]        o_tile,
    output logic [TILES-1:0]                   o_mask,
    output logic                               o_last
);

    localparam int DECK  = TILES - 1;
    localparam int IDX_W = $clog2(DECK);
    localparam int DW    = $clog2(DRAWS + 1);
    localparam int TW    = rtsm_pkg::TILE_W;
    localparam int PW    = rtsm_pkg::PROD_W;

    logic [TW-1:0]    r_free;
    logic [TW-1:0]    r_deck [DECK];
    logic [TW-1:0]    r_remaining;
    logic [TILES-1:0] r_mask;
    logic [DW-1:0]    r_draws;
    logic [PW-1:0]    r_prod;
    logic [TW-1:0]    r_rem;
    logic             r_out_valid;
    logic [TW-1:0]    r_out_tile;
    logic [TILES-1:0] r_out_mask;
    logic             r_out_last;

    logic [TW-1:0]    w_fill_src;
    logic [TW-1:0]    w_fill_deck [DECK];
    logic [TILES-1:0] w_fill_mask;
    logic [TW:0]      w_trial;
    logic [TW:0]      w_div;
    logic             w_empty;
    logic [TW-1:0]    w_pick;
    logic [TILES-1:0] w_pick_mask;
    logic [TILES-1:0] w_new_mask;
    logic             w_last;

    // rebuild source: reset value, freshly written value, or current free cell
    always_comb begin
        if (!i_rst_n) begin
            w_fill_src = rtsm_pkg::RESET_FREE;
        end else if (i_cfg_we) begin
            w_fill_src = i_cfg_data;
        end else begin
            w_fill_src = r_free;
        end
    end

    // tiles in order, free cell skipped; all entries built in parallel
    always_comb begin
        for (int n = 0; n < DECK; n++) begin
            w_fill_deck[n] = (TW'(n) >= w_fill_src) ? TW'(n + 1) : TW'(n);
        end
        for (int i = 0; i < TILES; i++) begin
            w_fill_mask[i] = (w_fill_src == TW'(i));
        end
    end

    // restoring modulo step
    assign w_div   = {1'b0, r_remaining};
    assign w_trial = {r_rem, r_prod[PW-1]};

    assign w_empty = (r_remaining == '0);
    assign w_pick  = w_empty ? '0 : r_deck[r_rem[IDX_W-1:0]];

    always_comb begin
        for (int i = 0; i < TILES; i++) begin
            w_pick_mask[i] = (w_pick == TW'(i));
        end
    end

    assign w_new_mask = w_empty ? r_mask : (r_mask | w_pick_mask);
    assign w_last     = ((DW + 1)'(r_draws) + 1'b1) >= (DW + 1)'(DRAWS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free      <= rtsm_pkg::RESET_FREE;
            r_remaining <= TW'(DECK);
            r_mask      <= w_fill_mask;
            r_draws     <= '0;
            r_out_valid <= 1'b0;
            for (int n = 0; n < DECK; n++) begin
                r_deck[n] <= w_fill_deck[n];
            end
        end else begin
            // a beat taken with no new one loaded empties the register
            if (i_out_ready && !(i_cmd.update && !i_cfg_we)) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                r_free      <= i_cfg_data;
                r_remaining <= TW'(DECK);
                r_mask      <= w_fill_mask;
                r_draws     <= '0;
                for (int n = 0; n < DECK; n++) begin
                    r_deck[n] <= w_fill_deck[n];
                end
            end else if (i_cmd.update) begin
                r_out_valid <= 1'b1;
                r_out_tile  <= w_pick;
                r_out_mask  <= w_new_mask;
                r_out_last  <= w_last;
                if (w_last) begin
                    r_remaining <= TW'(DECK);
                    r_mask      <= w_fill_mask;
                    r_draws     <= '0;
                    for (int n = 0; n < DECK; n++) begin
                        r_deck[n] <= w_fill_deck[n];
                    end
                end else begin
                    r_mask  <= w_new_mask;
                    r_draws <= r_draws + 1'b1;
                    if (!w_empty) begin
                        r_remaining <= r_remaining - 1'b1;
                        // close the gap: every entry at or above the pick moves down
                        for (int k = 0; k < DECK - 1; k++) begin
                            if (TW'(k) >= r_rem) begin
                                r_deck[k] <= r_deck[k + 1];
                            end
                        end
                    end
                end
            end
        end
    end

    // sample product and serial remainder
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prod <= PW'({{(PW - rtsm_pkg::SAMPLE_W){1'b0}}, i_random_byte}
                          * rtsm_pkg::PICK_MUL + rtsm_pkg::PICK_ADD);
            r_rem  <= '0;
        end else if (i_cmd.step) begin
            r_prod <= {r_prod[PW-2:0], 1'b0};
            if (w_trial >= w_div) begin
                r_rem <= TW'(w_trial - w_div);
            end else begin
                r_rem <= w_trial[TW-1:0];
            end
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_tile         = r_out_tile;
    assign o_mask         = r_out_mask;
    assign o_last         = r_out_last;

`ifndef SYNTHESIS
    // remainder stays below the divisor through the division
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_cmd.step) && (r_remaining != '0) |-> r_rem < r_remaining)
        else $error("modulo remainder not below deck count");

    // a draw inside a set shrinks the deck by exactly one
    a_deck_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update && !w_last && !w_empty && !i_cfg_we
        |=> r_remaining == $past(r_remaining) - 1'b1)
        else $error("deck count did not drop by one on a draw");

    // the free cell stays set in the running mask
    a_free_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_mask & w_fill_mask) == w_fill_mask || i_cfg_we)
        else $error("free cell missing from running mask");
`endif

endmodule
`default_nettype wire

### hdl/random_tile_subset_mask.sv
`default_nettype none
// ----------------------------------------------------------------------------
// random_tile_subset_mask
// Draws DRAWS distinct tiles out of TILES without replacement, one per sample.
// ----------------------------------------------------------------------------
// Flow: the sample beat is accepted, the 15-bit serial modulo then runs one
//   bit per cycle, and an update step loads the result beat.
// A new sample is taken only after the update of the last one; the serial
//   modulo unit sets the pace, and the update waits while a beat is not taken.
// Reset: synchronous, active low; free cell back to 12, deck and mask rebuilt
//   in the same cycle, no clearing pass.
// ----------------------------------------------------------------------------
module random_tile_subset_mask #(
    parameter int TILES = 25,   // 9 .. 32
    parameter int DRAWS = 4     // 1 .. 24
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    rtsm_in_if.sink                          i_smp,
    rtsm_out_if.source                       o_drw,
    input  wire logic                        i_cfg_we,
    input  wire logic [rtsm_pkg::TILE_W-1:0] i_cfg_data
);

    // Command/status pair between the sequencer and the datapath.
    rtsm_pkg::t_dp_cmd w_cmd;
    rtsm_pkg::t_dp_sts w_sts;

    // Sequencer: takes a sample beat only when idle, walks the modulo
    // steps, then waits for room in the output register before the update.
    rtsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (i_smp.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath: deck of free tiles, running mask, draw counter, the
    // (sample*107+7) mod remaining unit and the output beat register.
    // A free-cell write rebuilds the whole set at once.
    rtsm_dpath #(
        .TILES (TILES),
        .DRAWS (DRAWS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_random_byte (i_smp.random_byte),
        .i_out_ready   (o_drw.ready),
        .o_out_valid   (o_drw.valid),
        .o_tile        (o_drw.tile),
        .o_mask        (o_drw.mask),
        .o_last        (o_drw.last)
    );

endmodule
`default_nettype wire
